### sv/oe_pkg.sv
// Shared types and constants for the one-euro smoothing filter.
`timescale 1ns / 1ps

package oe_pkg;

    // Field widths
    localparam int VALUE_BITS = 32;
    localparam int TIME_BITS  = 48;
    localparam int SLOPE_BITS = 48;
    localparam int CUT_BITS   = 40;
    localparam int ALPHA_BITS = 31;

    // Shared unit widths
    localparam int ACC_W  = 80;
    localparam int OPND_W = 50;
    localparam int SHR_W  = 64;
    localparam int CNT_W  = 7;

    // Fixed-point constants
    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = 31'h4000_0000;
    localparam logic [TIME_BITS-1:0]  MIN_DT_US   = 48'd1000;
    localparam logic [19:0]           US_PER_S    = 20'd1000000;
    localparam logic [18:0]           TWO_PI_Q16  = 19'd411775;
    localparam logic [28:0]           K_SCALED    = 29'd256000000;
    localparam logic [43:0]           PRODUCT_MAX = 44'hFFF_FFFF_FFFF;
    localparam logic [CUT_BITS-1:0]   CUTOFF_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [46:0]           SLOPE_MAX   = 47'h7FFF_FFFF_FFFF;

    // Reset values of the configuration registers
    localparam logic [15:0] MIN_CUTOFF_RST = 16'd256;
    localparam logic [31:0] BETA_RST       = 32'd0;
    localparam logic [15:0] DCUTOFF_RST    = 16'd256;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_CUTOFF = 2'd0;
    localparam logic [1:0] CFG_BETA       = 2'd1;
    localparam logic [1:0] CFG_DCUTOFF    = 2'd2;

    // Input commands
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_RESET  = 1'b1;

    typedef enum logic
    {
        OP_MUL,
        OP_DIV
    } oe_op_t;

    // Command to the shared shift unit
    typedef struct packed
    {
        logic             start;
        oe_op_t           op;
        logic             clamp;
        logic [CNT_W-1:0] n;
    } oe_cmd_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_MAG,
        ST_SLOPE,
        ST_AGO,
        ST_AP,
        ST_AW,
        ST_AD,
        ST_BLEND_S,
        ST_BETA,
        ST_BLEND_V,
        ST_OUT
    } oe_state_t;

endpackage

### sv/one_euro_smoothing_filter.sv
// Top level of the one-euro adaptive smoothing filter.
// A first sample after reset gives its result in the cycle after the transfer;
// a filtered sample gives its result after 11 operations of the shift unit (slope
// multiply and divide, per alpha two multiplies and a divide, two blends, the beta
// product), each loaded and then stepped. A sample holds the input off until its result
// is taken; a reset command gives no result and leaves the input ready.
// Reset (rst_n low, async) clears state, cutoffs 1.0 Hz, beta 0.
`timescale 1ns / 1ps

module one_euro_smoothing_filter
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // [31:0] sample_value, [79:32] timestamp_us
    input  logic        s_axis_tuser,   // [0] command
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] filtered_value
    output logic        m_axis_tuser,   // [0] passed_through
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    oe_pkg::oe_state_t state_reg;
    oe_pkg::oe_state_t state_next;

    // configuration
    logic [15:0] min_cutoff_reg;
    logic [31:0] beta_reg;
    logic [15:0] dcutoff_reg;

    // filter state
    logic                            primed_reg;
    logic [oe_pkg::TIME_BITS-1:0]    last_time_reg;
    logic [oe_pkg::VALUE_BITS-1:0]   last_value_reg;
    logic [oe_pkg::SLOPE_BITS-1:0]   last_slope_reg;

    // per-item working registers
    logic [oe_pkg::VALUE_BITS-1:0]   v_in_reg;
    logic [oe_pkg::TIME_BITS-1:0]    t_in_reg;
    logic [oe_pkg::TIME_BITS-1:0]    dt_reg;
    logic                            slope_neg_reg;
    logic [46:0]                     slope_mag_reg;
    logic [oe_pkg::CUT_BITS-1:0]     cutoff_reg;
    logic                            phase_reg;
    logic                            blend_neg_reg;
    logic [oe_pkg::SLOPE_BITS-1:0]   s_hat_reg;

    // output register
    logic                            out_valid_reg;
    logic [oe_pkg::VALUE_BITS-1:0]   out_value_reg;
    logic                            out_pass_reg;

    // shared unit
    oe_pkg::oe_cmd_t                 unit_cmd;
    logic [oe_pkg::OPND_W-1:0]       unit_a;
    logic [oe_pkg::SHR_W-1:0]        unit_b;
    logic                            unit_done;
    logic [oe_pkg::ACC_W-1:0]        unit_acc;
    logic [oe_pkg::SHR_W-1:0]        unit_quo;

    logic                            in_xfer;
    logic [oe_pkg::VALUE_BITS-1:0]   in_value;
    logic [oe_pkg::TIME_BITS-1:0]    in_time;
    logic [oe_pkg::TIME_BITS-1:0]    dt_diff;
    logic [oe_pkg::TIME_BITS-1:0]    dt_val;
    logic [32:0]                     dv_in;
    logic [32:0]                     mag_in;
    logic [46:0]                     slope_q;
    logic [46:0]                     w_val;
    logic [47:0]                     denom;
    logic [58:0]                     alpha_num;
    logic [oe_pkg::ALPHA_BITS-1:0]   one_minus;
    logic [oe_pkg::ALPHA_BITS-1:0]   alpha;
    logic [48:0]                     target_slope;
    logic [48:0]                     d_slope;
    logic [48:0]                     m_slope;
    logic [32:0]                     d_value;
    logic [32:0]                     m_value;
    logic [oe_pkg::ACC_W-1:0]        rnd;
    logic [49:0]                     blend_r;
    logic [oe_pkg::SLOPE_BITS-1:0]   s_hat;
    logic [oe_pkg::VALUE_BITS-1:0]   v_hat;
    logic [55:0]                     bterm;
    logic [oe_pkg::CUT_BITS-1:0]     bterm_c;
    logic [oe_pkg::CUT_BITS:0]       cut_sum;
    logic [oe_pkg::CUT_BITS-1:0]     cut_val;

    assign in_value = s_axis_tdata[31:0];
    assign in_time  = s_axis_tdata[79:32];
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    // Arithmetic around the shared unit
    always_comb
    begin
        dt_diff = (in_time > last_time_reg) ? (in_time - last_time_reg) : '0;
        dt_val  = (dt_diff < oe_pkg::MIN_DT_US) ? oe_pkg::MIN_DT_US : dt_diff;
        dv_in   = {in_value[31], in_value} - {last_value_reg[31], last_value_reg};
        mag_in  = dv_in[32] ? (33'd0 - dv_in) : dv_in;

        slope_q = (unit_quo > {17'd0, oe_pkg::SLOPE_MAX}) ? oe_pkg::SLOPE_MAX
                                                           : unit_quo[46:0];

        w_val     = unit_acc[62:16];
        denom     = {1'b0, w_val} + {19'd0, oe_pkg::K_SCALED};
        alpha_num = {oe_pkg::K_SCALED, 30'd0} + {12'd0, denom[47:1]};
        one_minus = (unit_quo > {33'd0, oe_pkg::ALPHA_ONE}) ? oe_pkg::ALPHA_ONE
                                                            : unit_quo[30:0];
        alpha     = oe_pkg::ALPHA_ONE - one_minus;

        target_slope = slope_neg_reg ? (49'd0 - {2'd0, slope_mag_reg})
                                     : {2'd0, slope_mag_reg};
        d_slope = target_slope - {last_slope_reg[47], last_slope_reg};
        m_slope = d_slope[48] ? (49'd0 - d_slope) : d_slope;
        d_value = {v_in_reg[31], v_in_reg} - {last_value_reg[31], last_value_reg};
        m_value = d_value[32] ? (33'd0 - d_value) : d_value;

        // round half up of |d| * alpha / 2^30
        rnd     = unit_acc + {50'd0, 30'h2000_0000};
        blend_r = rnd[79:30];
        s_hat   = blend_neg_reg ? (last_slope_reg - blend_r[47:0])
                                : (last_slope_reg + blend_r[47:0]);
        v_hat   = blend_neg_reg ? (last_value_reg - blend_r[31:0])
                                : (last_value_reg + blend_r[31:0]);

        bterm   = unit_acc[79:24];
        bterm_c = (bterm >= {16'd0, oe_pkg::CUTOFF_MAX}) ? oe_pkg::CUTOFF_MAX
                                                         : bterm[39:0];
        cut_sum = {25'd0, min_cutoff_reg} + {1'b0, bterm_c};
        cut_val = (cut_sum > {1'b0, oe_pkg::CUTOFF_MAX}) ? oe_pkg::CUTOFF_MAX
                                                        : cut_sum[39:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oe_pkg::ST_IDLE:
                if (in_xfer && (s_axis_tuser == oe_pkg::CMD_FILTER))
                    state_next = primed_reg ? oe_pkg::ST_MAG : oe_pkg::ST_OUT;
            oe_pkg::ST_MAG:
                if (unit_done) state_next = oe_pkg::ST_SLOPE;
            oe_pkg::ST_SLOPE:
                if (unit_done) state_next = oe_pkg::ST_AGO;
            oe_pkg::ST_AGO:
                state_next = oe_pkg::ST_AP;
            oe_pkg::ST_AP:
                if (unit_done) state_next = oe_pkg::ST_AW;
            oe_pkg::ST_AW:
                if (unit_done) state_next = oe_pkg::ST_AD;
            oe_pkg::ST_AD:
                if (unit_done)
                    state_next = phase_reg ? oe_pkg::ST_BLEND_V : oe_pkg::ST_BLEND_S;
            oe_pkg::ST_BLEND_S:
                if (unit_done) state_next = oe_pkg::ST_BETA;
            oe_pkg::ST_BETA:
                if (unit_done) state_next = oe_pkg::ST_AGO;
            oe_pkg::ST_BLEND_V:
                if (unit_done) state_next = oe_pkg::ST_OUT;
            oe_pkg::ST_OUT:
                if (m_axis_tready) state_next = oe_pkg::ST_IDLE;
            default:
                state_next = oe_pkg::ST_IDLE;
        endcase
    end

    // Commands to the shared unit
    always_comb
    begin
        unit_cmd = '{start: 1'b0, op: oe_pkg::OP_MUL, clamp: 1'b0, n: '0};
        unit_a   = '0;
        unit_b   = '0;
        unique case (state_reg)
            oe_pkg::ST_IDLE:
                if (in_xfer && (s_axis_tuser == oe_pkg::CMD_FILTER) && primed_reg)
                begin
                    // |dv| * 1e6
                    unit_cmd = '{start: 1'b1, op: oe_pkg::OP_MUL, clamp: 1'b0, n: 7'd20};
                    unit_a   = {17'd0, mag_in};
                    unit_b   = {oe_pkg::US_PER_S, 44'd0};
                end
            oe_pkg::ST_MAG:
                if (unit_done)
                begin
                    // slope = product / dt
                    unit_cmd = '{start: 1'b1, op: oe_pkg::OP_DIV, clamp: 1'b0, n: 7'd52};
                    unit_a   = {2'd0, dt_reg};
                    unit_b   = {unit_acc[51:0], 12'd0};
                end
            oe_pkg::ST_AGO:
            begin
                // p = min(cutoff * dt, 2^44 - 1)
                unit_cmd = '{start: 1'b1, op: oe_pkg::OP_MUL, clamp: 1'b1, n: 7'd40};
                unit_a   = {2'd0, dt_reg};
                unit_b   = {cutoff_reg, 24'd0};
            end
            oe_pkg::ST_AP:
                if (unit_done)
                begin
                    unit_cmd = '{start: 1'b1, op: oe_pkg::OP_MUL, clamp: 1'b0, n: 7'd19};
                    unit_a   = {6'd0, unit_acc[43:0]};
                    unit_b   = {oe_pkg::TWO_PI_Q16, 45'd0};
                end
            oe_pkg::ST_AW:
                if (unit_done)
                begin
                    unit_cmd = '{start: 1'b1, op: oe_pkg::OP_DIV, clamp: 1'b0, n: 7'd59};
                    unit_a   = {2'd0, denom};
                    unit_b   = {alpha_num, 5'd0};
                end
            oe_pkg::ST_AD:
                if (unit_done)
                begin
                    unit_cmd = '{start: 1'b1, op: oe_pkg::OP_MUL, clamp: 1'b0, n: 7'd31};
                    unit_a   = phase_reg ? {17'd0, m_value} : {1'b0, m_slope};
                    unit_b   = {alpha, 33'd0};
                end
            oe_pkg::ST_BLEND_S:
                if (unit_done)
                begin
                    // beta * |s_hat|, taken from the value about to be stored
                    unit_cmd = '{start: 1'b1, op: oe_pkg::OP_MUL, clamp: 1'b0, n: 7'd32};
                    unit_a   = {2'd0, (s_hat[47] ? (48'd0 - s_hat) : s_hat)};
                    unit_b   = {beta_reg, 32'd0};
                end
            default:
            begin
                unit_cmd = '{start: 1'b0, op: oe_pkg::OP_MUL, clamp: 1'b0, n: '0};
            end
        endcase
    end

    oe_shift_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (unit_cmd),
        .a     (unit_a),
        .b     (unit_b),
        .done  (unit_done),
        .acc   (unit_acc),
        .quo   (unit_quo)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= oe_pkg::ST_IDLE;
            min_cutoff_reg <= oe_pkg::MIN_CUTOFF_RST;
            beta_reg       <= oe_pkg::BETA_RST;
            dcutoff_reg    <= oe_pkg::DCUTOFF_RST;
            primed_reg     <= 1'b0;
            last_time_reg  <= '0;
            last_value_reg <= '0;
            last_slope_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    oe_pkg::CFG_MIN_CUTOFF: min_cutoff_reg <= cfg_data[15:0];
                    oe_pkg::CFG_BETA:       beta_reg       <= cfg_data;
                    oe_pkg::CFG_DCUTOFF:    dcutoff_reg    <= cfg_data[15:0];
                    default:                ;
                endcase
            end

            // state updates on a command, a first sample or a finished blend
            if (in_xfer && (s_axis_tuser == oe_pkg::CMD_RESET))
            begin
                primed_reg     <= 1'b0;
                last_time_reg  <= '0;
                last_value_reg <= '0;
                last_slope_reg <= '0;
            end
            else if (in_xfer && !primed_reg)
            begin
                primed_reg     <= 1'b1;
                last_time_reg  <= in_time;
                last_value_reg <= in_value;
                last_slope_reg <= '0;
            end
            else if ((state_reg == oe_pkg::ST_BLEND_V) && unit_done)
            begin
                last_time_reg  <= t_in_reg;
                last_value_reg <= v_hat;
                last_slope_reg <= s_hat_reg;
            end

            if (state_reg == oe_pkg::ST_OUT && m_axis_tready)
                out_valid_reg <= 1'b0;
            else if (state_next == oe_pkg::ST_OUT && state_reg != oe_pkg::ST_OUT)
                out_valid_reg <= 1'b1;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            v_in_reg      <= in_value;
            t_in_reg      <= in_time;
            dt_reg        <= dt_val;
            slope_neg_reg <= dv_in[32];
            out_value_reg <= in_value;
            out_pass_reg  <= 1'b1;
        end
        if ((state_reg == oe_pkg::ST_SLOPE) && unit_done)
        begin
            slope_mag_reg <= slope_q;
            cutoff_reg    <= {24'd0, dcutoff_reg};
            phase_reg     <= 1'b0;
        end
        if ((state_reg == oe_pkg::ST_AD) && unit_done)
            blend_neg_reg <= phase_reg ? d_value[32] : d_slope[48];
        if ((state_reg == oe_pkg::ST_BLEND_S) && unit_done)
            s_hat_reg <= s_hat;
        if ((state_reg == oe_pkg::ST_BETA) && unit_done)
        begin
            cutoff_reg <= cut_val;
            phase_reg  <= 1'b1;
        end
        if ((state_reg == oe_pkg::ST_BLEND_V) && unit_done)
        begin
            out_value_reg <= v_hat;
            out_pass_reg  <= 1'b0;
        end
    end

    assign s_axis_tready = (state_reg == oe_pkg::ST_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_pass_reg;

endmodule

### sv/oe_shift_unit.sv
// Shared bit-serial multiply (shift-add) and divide (shift-subtract) unit.
`timescale 1ns / 1ps

module oe_shift_unit
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  oe_pkg::oe_cmd_t          cmd,
    input  logic [oe_pkg::OPND_W-1:0] a,   // multiplicand or divisor
    input  logic [oe_pkg::SHR_W-1:0]  b,   // multiplier or dividend, MSB aligned
    output logic                     done,
    output logic [oe_pkg::ACC_W-1:0]  acc,  // product, or remainder of a divide
    output logic [oe_pkg::SHR_W-1:0]  quo   // quotient in the low bits
);

    logic                      busy_reg;
    logic                      done_reg;
    logic [oe_pkg::CNT_W-1:0]  cnt_reg;
    oe_pkg::oe_op_t            op_reg;
    logic                      clamp_reg;
    logic [oe_pkg::OPND_W-1:0] a_reg;
    logic [oe_pkg::SHR_W-1:0]  b_reg;
    logic [oe_pkg::ACC_W-1:0]  acc_reg;

    logic [oe_pkg::ACC_W-1:0]  acc_next;
    logic [oe_pkg::SHR_W-1:0]  b_next;
    logic [oe_pkg::ACC_W-1:0]  mul_sum;
    logic [48:0]               div_t;
    logic                      div_ge;
    logic [48:0]               div_rem;

    // One step of the selected operation
    always_comb
    begin
        mul_sum = {acc_reg[oe_pkg::ACC_W-2:0], 1'b0}
                + (b_reg[oe_pkg::SHR_W-1] ? {30'd0, a_reg} : '0);
        div_t   = {acc_reg[47:0], b_reg[oe_pkg::SHR_W-1]};
        div_ge  = ({1'b0, div_t} >= a_reg);
        div_rem = div_ge ? (div_t - a_reg[48:0]) : div_t;
        unique case (op_reg)
            oe_pkg::OP_MUL:
            begin
                if (clamp_reg && (mul_sum > {36'd0, oe_pkg::PRODUCT_MAX}))
                    acc_next = {36'd0, oe_pkg::PRODUCT_MAX};
                else
                    acc_next = mul_sum;
                b_next = {b_reg[oe_pkg::SHR_W-2:0], 1'b0};
            end
            oe_pkg::OP_DIV:
            begin
                acc_next = {31'd0, div_rem};
                b_next   = {b_reg[oe_pkg::SHR_W-2:0], div_ge};
            end
            default:
            begin
                acc_next = acc_reg;
                b_next   = b_reg;
            end
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= cmd.n;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == oe_pkg::CNT_W'(1));
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - oe_pkg::CNT_W'(1);
                if (cnt_reg == oe_pkg::CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg    <= cmd.op;
            clamp_reg <= cmd.clamp;
            a_reg     <= a;
            b_reg     <= b;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign quo  = b_reg;

endmodule

### sv/oe_checker.sv
// Port-level checker for the one-euro smoothing filter, bound to the top level.
`timescale 1ns / 1ps

module oe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a new item is never taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while result pending");

    // a reset command gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == oe_pkg::CMD_RESET)
        |=> !m_axis_tvalid)
    else $error("result after reset command");

    // a sample makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == oe_pkg::CMD_FILTER)
        |=> !s_axis_tready)
    else $error("ready right after a sample");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind one_euro_smoothing_filter oe_checker u_oe_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### dv/tb.sv
// Self-checking testbench for the one-euro smoothing filter: stream stimulus, model check.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_CYCLES = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = oe_pkg::CFG_MIN_CUTOFF;
    logic [31:0] cfg_data = '0;

    one_euro_smoothing_filter dut (.*);

    always #5 clk = ~clk;

    typedef struct packed
    {
        logic        cmd;
        logic [31:0] value;
        logic [47:0] stamp;
    } sample_t;

    typedef struct packed
    {
        logic [31:0] value;
        logic        passed;
    } smooth_t;

    sample_t pending_q[$];
    smooth_t smoothed_q[$];

    // predictor copy of filter state and registers
    logic [15:0]        p_min_cut;
    logic [31:0]        p_beta;
    logic [15:0]        p_dcut;
    logic               p_primed;
    logic [47:0]        p_last_t;
    longint             p_last_v;
    longint             p_last_s;

    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_tx = 1'b0;
    bit  in_taken = 1'b0;
    int  rx_stall = 0;
    int  rx_gap = 0;
    int  tx_gap = 0;

    function automatic longint unsigned mul_sat(longint unsigned a, longint unsigned b);
        if (b != 0 && a > 64'hFFFF_FFFF_FFFF_FFFF / b)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        return a * b;
    endfunction

    function automatic longint unsigned alpha_for(longint unsigned cut, longint unsigned dt);
        longint unsigned p, w, den, om;
        p = mul_sat(cut, dt);
        if (p > 64'hFFF_FFFF_FFFF)
            p = 64'hFFF_FFFF_FFFF;
        w = (p * 64'd411775) >> 16;
        den = w + 64'd256000000;
        om = ((64'd256000000 << 30) + den / 2) / den;
        if (om > (64'd1 << 30))
            om = 64'd1 << 30;
        return (64'd1 << 30) - om;
    endfunction

    function automatic longint mix(longint old, longint target, longint unsigned a);
        longint d;
        longint unsigned m, r;
        d = target - old;
        m = (d < 0) ? longint'(-d) : longint'(d);
        r = (m >> 30) * a + (((m & 64'h3FFF_FFFF) * a + (64'd1 << 29)) >> 30);
        return (d < 0) ? old - longint'(r) : old + longint'(r);
    endfunction

    // append one expected result
    task automatic put_result(smooth_t r);
        smoothed_q = {smoothed_q, r};
    endtask

    // advance predictor by one accepted sample
    task automatic predict_sample(sample_t it);
        longint v, dv, slope, sh, vh;
        longint unsigned dt, mag, smag, cut, ad, av;
        smooth_t r;
        v = longint'(signed'(it.value));
        if (it.cmd == oe_pkg::CMD_RESET)
        begin
            p_primed = 1'b0;
            p_last_t = '0;
            p_last_v = 0;
            p_last_s = 0;
            return;
        end
        if (!p_primed)
        begin
            p_primed = 1'b1;
            p_last_t = it.stamp;
            p_last_v = v;
            p_last_s = 0;
            r.value = it.value;
            r.passed = 1'b1;
            put_result(r);
            return;
        end
        dt = (it.stamp > p_last_t) ? 64'(it.stamp - p_last_t) : 64'd0;
        if (dt < 1000)
            dt = 1000;
        dv = v - p_last_v;
        mag = (dv < 0) ? longint'(-dv) : longint'(dv);
        mag = mul_sat(mag, 64'd1000000) / dt;
        if (mag > 64'h7FFF_FFFF_FFFF)
            mag = 64'h7FFF_FFFF_FFFF;
        slope = (dv < 0) ? -longint'(mag) : longint'(mag);
        ad = alpha_for(64'(p_dcut), dt);
        sh = mix(p_last_s, slope, ad);
        smag = (sh < 0) ? longint'(-sh) : longint'(sh);
        cut = 64'(p_min_cut) + (mul_sat(64'(p_beta), smag) >> 24);
        if (cut > 64'hFF_FFFF_FFFF)
            cut = 64'hFF_FFFF_FFFF;
        av = alpha_for(cut, dt);
        vh = mix(p_last_v, v, av);
        p_last_t = it.stamp;
        p_last_v = vh;
        p_last_s = sh;
        r.value = vh[31:0];
        r.passed = 1'b0;
        put_result(r);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // driver: offers items from the pending queue, holding each until its transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (in_taken)
                begin
                    in_taken = 1'b0;
                    tx_gap = pick_gap();
                end
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0 && !hold_tx)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {pending_q[0].stamp, pending_q[0].value};
                    s_axis_tuser <= pending_q[0].cmd;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver readiness: random gaps and a counted long stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_gap = pick_gap();
            end
        end
    end

    // monitor: take input transfers, compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        smooth_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready)
            begin
                idle_cycles = 0;
                predict_sample(pending_q.pop_front());
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                idle_cycles = 0;
                if (smoothed_q.size() == 0)
                begin
                    $display("%0t unexpected result value=%h passed=%b", $time,
                             m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    want = smoothed_q.pop_front();
                    if (want.value !== m_axis_tdata)
                    begin
                        $display("%0t filtered_value expected %h actual %h", $time,
                                 want.value, m_axis_tdata);
                        errors++;
                    end
                    if (want.passed !== m_axis_tuser)
                    begin
                        $display("%0t passed_through expected %b actual %b", $time,
                                 want.passed, m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("one_euro_smoothing_filter: mismatch");
                $finish;
            end
        end
    end

    task automatic add_item(logic cmd, logic [31:0] v, logic [47:0] t);
        sample_t it;
        it.cmd = cmd;
        it.value = v;
        it.stamp = t;
        pending_q = {pending_q, it};
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            oe_pkg::CFG_MIN_CUTOFF: p_min_cut = d[15:0];
            oe_pkg::CFG_BETA:       p_beta = d;
            default:                p_dcut = d[15:0];
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_axis_tvalid || smoothed_q.size() > 0)
            @(negedge clk);
        repeat (500) @(negedge clk);
    endtask

    // random sample value: small moves half the time, else random or extreme
    function automatic logic [31:0] rand_value(logic [31:0] prev);
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
            default: return prev + 32'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    function automatic logic [47:0] rand_step();
        case ($urandom_range(0, 7))
            0: return 48'({$urandom(), $urandom()});
            1: return 48'd0 - 48'($urandom_range(0, 5000));
            2: return 48'($urandom_range(0, 999));
            default: return 48'($urandom_range(1000, 200000));
        endcase
    endfunction

    // one phase of well-formed streams with random content and a few resets
    task automatic random_phase(int count);
        logic [31:0] v;
        logic [47:0] t;
        v = $urandom();
        t = 48'({$urandom(), $urandom()});
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                add_item(oe_pkg::CMD_RESET, $urandom(), 48'({$urandom(), $urandom()}));
            else
            begin
                v = rand_value(v);
                t = t + rand_step();
                add_item(oe_pkg::CMD_FILTER, v, t);
            end
        end
    endtask

    initial
    begin
        p_min_cut = oe_pkg::MIN_CUTOFF_RST;
        p_beta = oe_pkg::BETA_RST;
        p_dcut = oe_pkg::DCUTOFF_RST;
        p_primed = 1'b0;
        p_last_t = '0;
        p_last_v = 0;
        p_last_s = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: first sample, extremes, backward time, reset command
        add_item(oe_pkg::CMD_FILTER, 32'h0001_0000, 48'd0);
        add_item(oe_pkg::CMD_FILTER, 32'h7FFF_FFFF, 48'd10);
        add_item(oe_pkg::CMD_FILTER, 32'h8000_0000, 48'd5000);
        add_item(oe_pkg::CMD_FILTER, 32'h8000_0000, 48'd4000);
        add_item(oe_pkg::CMD_FILTER, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
        add_item(oe_pkg::CMD_FILTER, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        add_item(oe_pkg::CMD_RESET, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        add_item(oe_pkg::CMD_FILTER, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        add_item(oe_pkg::CMD_FILTER, 32'h0000_0000, 48'd0);
        add_item(oe_pkg::CMD_FILTER, 32'h1234_5678, 48'd1000000);
        add_item(oe_pkg::CMD_RESET, 32'd0, 48'd0);
        add_item(oe_pkg::CMD_RESET, 32'd0, 48'd0);
        add_item(oe_pkg::CMD_FILTER, 32'hFFFF_0000, 48'd77);
        add_item(oe_pkg::CMD_FILTER, 32'h0001_0000, 48'd1077);
        drain();

        // zero cutoffs hold the state; then the extremes
        write_reg(oe_pkg::CFG_MIN_CUTOFF, 32'd0);
        write_reg(oe_pkg::CFG_BETA, 32'd0);
        write_reg(oe_pkg::CFG_DCUTOFF, 32'd0);
        add_item(oe_pkg::CMD_FILTER, 32'h4000_0000, 48'd2000000);
        add_item(oe_pkg::CMD_FILTER, 32'hC000_0000, 48'd3000000);
        drain();
        write_reg(oe_pkg::CFG_MIN_CUTOFF, 32'hFFFF);
        write_reg(oe_pkg::CFG_BETA, 32'hFFFF_FFFF);
        write_reg(oe_pkg::CFG_DCUTOFF, 32'hFFFF);
        add_item(oe_pkg::CMD_FILTER, 32'h0000_0000, 48'd4000000);
        add_item(oe_pkg::CMD_FILTER, 32'h7FFF_FFFF, 48'd4001000);
        drain();

        // receiver holds off while the sender keeps offering
        rx_stall = 3000;
        random_phase(20);
        while (rx_stall > 0)
            @(negedge clk);
        drain();

        // random phases across several register settings
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(oe_pkg::CFG_MIN_CUTOFF, (ph % 3 == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 2048));
            write_reg(oe_pkg::CFG_BETA, (ph == 9) ? 32'hFFFF_FFFF :
                      (ph % 2 ? $urandom() : $urandom_range(0, 65536)));
            write_reg(oe_pkg::CFG_DCUTOFF, (ph == 8) ? 32'd0 :
                      (ph % 3 == 1 ? $urandom_range(0, 65535)
                                   : $urandom_range(0, 2048)));
            random_phase(105);
            // sender pauses midway until all results are back
            if (ph == 4)
            begin
                while (pending_q.size() > 50)
                    @(negedge clk);
                hold_tx = 1'b1;
                @(negedge clk);
                while (s_axis_tvalid || smoothed_q.size() > 0)
                    @(negedge clk);
                repeat (20) @(negedge clk);
                hold_tx = 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("one_euro_smoothing_filter: match");
        else
            $display("one_euro_smoothing_filter: mismatch");
        $finish;
    end
endmodule
